// ----- rtl/core/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhpq_pkg - shared types and codes for the max-heap priority queue
// Operation codes, status codes and the operation bundle that the top level
// broadcasts to every storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

    localparam int VALUE_W = 32;

    typedef logic [1:0]                t_status;
    typedef logic signed [VALUE_W-1:0] t_value;

    // operation codes on the mode field
    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    // result status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // value returned by an extract on an empty queue
    localparam t_value EMPTY_VALUE = -32'sd1;

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic   ins;    // insert value into the sorted chain
        logic   ext;    // remove head, chain shifts toward the head
        t_value value;  // value being inserted
    } t_cell_op;

endpackage

`default_nettype wire

// ----- rtl/core/mhpq_cell.sv -----
// ----------------------------------------------------------------------------
// mhpq_cell - one storage cell of the sorted priority chain
// Holds one value. On insert the cell keeps its value, takes the new value,
// or takes its left neighbor's value; on extract it takes its right
// neighbor's value. The chain stays sorted largest first.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_cell
    import mhpq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_cell_op i_op,
    input  wire logic     i_occupied,   // cell holds a live value
    input  wire logic     i_left_keep,  // left neighbor keeps its value
    input  wire t_value   i_left_val,
    input  wire t_value   i_right_val,
    output logic          o_keep,
    output t_value        o_val
);

    t_value r_val;
    t_value n_val;

    // keep own value when it is live and not smaller than the new one
    assign o_keep = i_occupied && !(i_op.value > r_val);
    assign o_val  = r_val;

    // pick next value: hold, take new value, shift right, or shift left
    always_comb begin
        n_val = r_val;
        if (i_op.ins) begin
            if (o_keep) begin
                n_val = r_val;
            end else if (i_left_keep) begin
                n_val = i_op.value;
            end else begin
                n_val = i_left_val;
            end
        end else if (i_op.ext) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

// ----- rtl/core/max_heap_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core - priority queue of signed 32-bit values
// Insert adds a value, extract returns the largest one. Values live in a
// chain of cells kept sorted largest first, so the head cell is the maximum.
//
//   channel   direction  handshake          payload
//   input     in         i_valid / o_ready  i_mode, i_value
//   result    out        o_valid / i_ready  o_top_value, o_status, o_entries
//
// All cells compare against the new value in parallel and shift by one
// place, so the chain settles on the edge that accepts the item.
// The result is registered and is valid in the cycle after the input transfer.
// The result register frees up when its transfer completes, so a new item
// is taken in the same cycle as a result is drained.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue_core
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_mode,
    input  wire logic signed [VALUE_W-1:0]     i_value,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [VALUE_W-1:0]          o_top_value,
    output logic [1:0]                         o_status,
    output logic [$clog2(CAPACITY+1)-1:0]      o_entries
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_value           r_top;
    t_status          r_status;
    logic             accept;
    logic             full;
    logic             empty;
    t_cell_op         op;

    t_value cell_val  [CAPACITY];
    logic   cell_keep [CAPACITY];

    assign full    = (r_count == CNT_W'(CAPACITY));
    assign empty   = (r_count == '0);
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // build the operation broadcast to the chain
    always_comb begin
        op.ins   = accept && (i_mode == MODE_INSERT) && !full;
        op.ext   = accept && (i_mode == MODE_EXTRACT) && !empty;
        op.value = i_value;
    end

    // advance the fill count
    always_comb begin
        n_count = r_count;
        if (op.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (op.ext) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // chain of cells, head at index zero
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   left_keep;
        t_value left_val;
        t_value right_val;

        if (g == 0) begin : g_head
            assign left_keep = 1'b1;
            assign left_val  = i_value;
        end else begin : g_body
            assign left_keep = cell_keep[g-1];
            assign left_val  = cell_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_val = cell_val[g];
        end else begin : g_inner
            assign right_val = cell_val[g+1];
        end

        mhpq_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (op),
            .i_occupied  (r_count > CNT_W'(g)),
            .i_left_keep (left_keep),
            .i_left_val  (left_val),
            .i_right_val (right_val),
            .o_keep      (cell_keep[g]),
            .o_val       (cell_val[g])
        );
    end

    // control state: fill count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // capture result payload on transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_mode == MODE_EXTRACT) begin
                r_top    <= empty ? EMPTY_VALUE : cell_val[0];
                r_status <= empty ? ST_EMPTY : ST_OK;
            end else begin
                r_top    <= '0;
                r_status <= full ? ST_FULL : ST_OK;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_top_value = r_top;
    assign o_status    = r_status;
    assign o_entries   = r_count;

`ifndef SYNTH
    // fill count stays within capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    // head is never smaller than its successor
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> !(cell_val[1] > cell_val[0]))
        else $error("chain head out of order");

    // successful extract removes exactly one entry
    a_extract_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op.ext |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("extract did not remove one entry");

    // a dropped insert leaves the count at capacity
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode == MODE_INSERT) && full) |=>
            ((r_status == ST_FULL) && (r_count == CNT_W'(CAPACITY))))
        else $error("full insert not flagged");

    // result status is always a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status == ST_OK || r_status == ST_EMPTY ||
                         r_status == ST_FULL))
        else $error("undefined status code");
`endif

endmodule

`default_nettype wire
